// ===== rtl/mldd_pkg.sv =====
// ----------------------------------------------------------------------------
// mldd_pkg
// Shared constants, types and helpers for the microphone level dip detector.
// ----------------------------------------------------------------------------
package mldd_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int WINDOW_DEF  = 10;

    localparam int SENS_W      = 7;
    localparam int THR_W       = 11;
    localparam int DIP_SCALE   = 10;
    localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(20);

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;

    // result beat layout, lowest bit first
    localparam int OUT_TRIG_BIT  = 0;
    localparam int OUT_AVG_LSB   = 1;
    localparam int OUT_VALID_BIT = OUT_AVG_LSB + SAMPLE_BITS;
    localparam int OUT_USED_W    = OUT_VALID_BIT + 1;
    localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_USED_W;

    typedef logic [SAMPLE_BITS-1:0] t_sample;
    typedef logic [THR_W-1:0]       t_thresh;

    // sensitivity * 10 as shift-add
    function automatic t_thresh thresh_of(input logic [SENS_W-1:0] sens);
        t_thresh s_ext;
        s_ext = THR_W'(sens);
        return (s_ext << 3) + (s_ext << 1);
    endfunction

endpackage

// ===== rtl/mic_level_dip_detector.sv =====
// ----------------------------------------------------------------------------
// mic_level_dip_detector
// Moving average over the last WINDOW microphone samples; flags a sample
// that dips below the average by more than ten times the sensitivity.
// ----------------------------------------------------------------------------
//  channel   dir  signals                              content
//  s_axis    in   i_s_axis_tvalid/tready/tdata         sample
//  m_axis    out  o_m_axis_tvalid/tready/tdata         triggered, average, window_valid
//  cfg       in   i_cfg_wr_en, i_cfg_wr_data           sensitivity
//
//  One beat per cycle in, one per cycle out while the output is not stalled.
//  Stage one updates the ring and the running sum; stage two divides by
//  WINDOW (reciprocal multiply) and compares against the threshold.
//  The ring read for the next slot is prefetched into a register.
//  Synchronous active-low reset clears the window; the ring is not cleared.
//  Output stalls back up into stage one and then into o_s_axis_tready.
// ----------------------------------------------------------------------------
module mic_level_dip_detector
    import mldd_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   i_s_axis_tdata,   // [9:0] sample

    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  o_m_axis_tdata,   // [0] triggered, [10:1] average,
                                                      // [11] window_valid

    input  logic                    i_cfg_wr_en,
    input  logic [SENS_W-1:0]       i_cfg_wr_data     // sensitivity
);

    localparam int IDX_W   = $clog2(WINDOW);
    localparam int SUM_W   = SAMPLE_BITS + IDX_W;
    localparam int DIV_K   = SUM_W + IDX_W;
    localparam int RECIP_W = DIV_K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam logic [63:0] RECIP64 =
        ((64'd1 << DIV_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RECIP_W-1:0] RECIP    = RECIP64[RECIP_W-1:0];
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW - 1);

    t_sample                 ring [WINDOW];

    logic                    r_v1;
    logic                    r_out_v;
    logic [IDX_W-1:0]        r_widx;
    logic [SUM_W-1:0]        r_sum;
    logic                    r_filled;
    t_thresh                 r_thresh;
    t_sample                 r_smp;
    t_sample                 r_old;
    logic [OUT_TDATA_W-1:0]  r_odata;

    logic [IDX_W-1:0]        n_widx;
    logic [SUM_W-1:0]        n_sum;
    logic                    n_filled;
    logic [OUT_TDATA_W-1:0]  n_odata;

    logic                    s_acc;
    logic                    adv;
    logic                    wrap;
    t_sample                 smp;
    t_sample                 old_smp;
    logic [IDX_W-1:0]        rd_addr;
    logic [PROD_W-1:0]       prod;
    t_sample                 avg;
    t_sample                 avg_out;
    t_sample                 diff;
    logic                    trig;

    // stage one: ring and running sum
    assign adv             = r_v1 && (!r_out_v || i_m_axis_tready);
    assign o_s_axis_tready = !r_v1 || adv;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    assign smp      = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign wrap     = (r_widx == LAST_IDX);
    assign n_widx   = wrap ? '0 : r_widx + 1'b1;
    assign n_filled = r_filled | wrap;
    assign old_smp  = r_filled ? r_old : '0;
    assign n_sum    = r_sum - SUM_W'(old_smp) + SUM_W'(smp);
    assign rd_addr  = s_acc ? n_widx : r_widx;

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            ring[r_widx] <= smp;
        end
        r_old <= ring[rd_addr];
    end

    // stage two: divide by WINDOW and compare
    assign prod    = PROD_W'(r_sum) * PROD_W'(RECIP);
    assign avg     = prod[DIV_K +: SAMPLE_BITS];
    assign avg_out = r_filled ? avg : '0;
    assign diff    = avg - r_smp;
    assign trig    = r_filled && (avg > r_smp) &&
                     ({{(THR_W-SAMPLE_BITS){1'b0}}, diff} > r_thresh);
    assign n_odata = {{OUT_PAD_W{1'b0}}, r_filled, avg_out, trig};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_out_v  <= 1'b0;
            r_widx   <= '0;
            r_sum    <= '0;
            r_filled <= 1'b0;
            r_thresh <= thresh_of(SENS_RESET);
        end else begin
            r_v1    <= s_acc | (r_v1 & !adv);
            r_out_v <= adv | (r_out_v & !i_m_axis_tready);
            if (s_acc) begin
                r_widx   <= n_widx;
                r_sum    <= n_sum;
                r_filled <= n_filled;
            end
            if (i_cfg_wr_en) begin
                r_thresh <= thresh_of(i_cfg_wr_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_smp <= smp;
        end
        if (adv) begin
            r_odata <= n_odata;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_odata;

endmodule

// ===== rtl/mldd_checker.sv =====
// ----------------------------------------------------------------------------
// mldd_checker
// Port-level checks for the microphone level dip detector result stream.
// ----------------------------------------------------------------------------
module mldd_checker
    import mldd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_m_tvalid,
    input  logic                    i_m_tready,
    input  logic [OUT_TDATA_W-1:0]  i_m_tdata     // [0] triggered, [10:1] average,
                                                  // [11] window_valid
);

    logic r_seen_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_valid <= 1'b0;
        end else if (i_m_tvalid && i_m_tready && i_m_tdata[OUT_VALID_BIT]) begin
            r_seen_valid <= 1'b1;
        end
    end

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata))
        else $error("result beat changed while stalled");

    // no trigger before the window fills
    a_trig_needs_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tdata[OUT_VALID_BIT] |->
            !i_m_tdata[OUT_TRIG_BIT] &&
            (i_m_tdata[OUT_VALID_BIT-1:OUT_AVG_LSB] == '0))
        else $error("trigger or average set before window valid");

    // window valid never drops once seen
    a_valid_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && r_seen_valid |-> i_m_tdata[OUT_VALID_BIT])
        else $error("window valid dropped");

    // reset empties the output
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result beat after reset");

endmodule

bind mic_level_dip_detector mldd_checker u_mldd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_axis_tvalid),
    .i_m_tready (i_m_axis_tready),
    .i_m_tdata  (o_m_axis_tdata)
);

// ===== tb/tb_mic_level_dip_detector.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mic_level_dip_detector
// Streams microphone samples into the dip detector and compares every result
// beat with a moving-average predictor kept in the bench. It covers the window
// fill, the sample extremes, the trigger edges and the full sensitivity range.
// Random traffic is mostly steady levels followed by a dip near the threshold.
// The sender works in bursts with gaps, and the receiver stalls on a pattern.
// ----------------------------------------------------------------------------
module tb_mic_level_dip_detector;
    import mldd_pkg::*;

    localparam int DRAIN_CYCLES   = 8;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 119;
    localparam int MAX_PRINTS     = 20;

    typedef struct {
        logic    triggered;
        t_sample average;
        logic    window_valid;
    } t_level_result;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_wr_en = 1'b0;
    logic [SENS_W-1:0]      cfg_wr_data = '0;

    // averaging state of the predictor
    t_sample           win_ring [WINDOW_DEF];
    int                win_ptr;
    int                win_sum;
    logic              win_full;
    int                avg_held;
    logic [SENS_W-1:0] sens_now;

    t_level_result     pending_levels[$];
    int                err_cnt = 0;
    int                burst_left = 0;
    int                idle_cycles = 0;
    int                rx_mode = 0;
    int                rx_left = 0;

    mic_level_dip_detector uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_wr_data   (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        end
    endtask

    task automatic clear_window();
        win_ptr  = 0;
        win_sum  = 0;
        win_full = 1'b0;
        avg_held = 0;
        sens_now = SENS_RESET;
        foreach (win_ring[k]) win_ring[k] = '0;
    endtask

    function automatic void predict_level(input t_sample s);
        t_level_result r;
        if (win_full) begin
            win_sum -= int'(win_ring[win_ptr]);
        end
        win_sum += int'(s);
        win_ring[win_ptr] = s;
        if (win_ptr == WINDOW_DEF - 1) begin
            win_ptr  = 0;
            win_full = 1'b1;
        end else begin
            win_ptr++;
        end
        r.triggered    = 1'b0;
        r.average      = '0;
        r.window_valid = win_full;
        if (win_full) begin
            avg_held  = win_sum / WINDOW_DEF;
            r.average = t_sample'(avg_held);
            if (avg_held > int'(s) && (avg_held - int'(s)) > int'(sens_now) * DIP_SCALE) begin
                r.triggered = 1'b1;
            end
        end
        pending_levels.push_back(r);
    endfunction

    function automatic t_sample clamp_sample(input int v);
        if (v < 0) return '0;
        if (v > (1 << SAMPLE_BITS) - 1) return '1;
        return t_sample'(v);
    endfunction

    // valid stays high after a beat; a gap or stop_stream lowers it
    task automatic send_sample(input t_sample s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(s);
        do @(posedge i_clk); while (!s_tready);
        predict_level(s);
    endtask

    task automatic stop_stream();
        s_tvalid  <= 1'b0;
        burst_left = 0;
    endtask

    task automatic write_sensitivity(input logic [SENS_W-1:0] v);
        stop_stream();
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        sens_now     = v;
    endtask

    // first valid result already dips far below a full-scale window
    task automatic test_window_fill();
        repeat (WINDOW_DEF - 1) send_sample('1);
        send_sample('0);
        send_sample('0);
        send_sample(t_sample'(512));
    endtask

    // zero sensitivity: sample equal to average must not trigger, a dip below it must
    task automatic test_dip_edges();
        write_sensitivity('0);
        repeat (WINDOW_DEF) send_sample(t_sample'(700));
        send_sample(t_sample'(699));
        send_sample(t_sample'(690));
    endtask

    task automatic test_sensitivity_ceiling();
        write_sensitivity('1);
        send_sample('0);
        send_sample('0);
    endtask

    task automatic test_random_dips();
        int                done;
        int                level;
        int                run_len;
        int                dip;
        logic [SENS_W-1:0] sens_pick;
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: sens_pick = '0;
                1: sens_pick = SENS_W'(1);
                2: sens_pick = SENS_W'(100);
                3: sens_pick = '1;
                4: sens_pick = SENS_RESET;
                5: sens_pick = SENS_W'($urandom_range(0, 127));
                default: sens_pick = SENS_W'($urandom_range(2, 40));
            endcase
            write_sensitivity(sens_pick);
            done = 0;
            while (done < RAND_PER_PHASE) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_sample(t_sample'($urandom_range(0, 1023)));
                    done++;
                end else begin
                    level   = int'($urandom_range(0, 1023));
                    run_len = int'($urandom_range(3, 12));
                    repeat (run_len) begin
                        send_sample(clamp_sample(level + int'($urandom_range(0, 8)) - 4));
                        done++;
                    end
                    dip = int'(sens_pick) * DIP_SCALE + int'($urandom_range(0, 40)) - 20;
                    if ($urandom_range(0, 3) == 0) dip = int'($urandom_range(0, 1023));
                    send_sample(clamp_sample(level - dip));
                    done++;
                end
            end
        end
    endtask

    // receiver: free flow, random, sparse, or long stall runs
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= int'($urandom_range(0, 3));
            rx_left <= int'($urandom_range(20, 200));
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (rx_left[1:0] == 2'b00);
            default: m_tready <= !rx_left[4];
        endcase
    end

    always @(posedge i_clk) begin
        t_level_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                report_mismatch("unexpected beat", int'(m_tdata), 0);
            end else begin
                want = pending_levels.pop_front();
                if (m_tdata[OUT_TRIG_BIT] !== want.triggered)
                    report_mismatch("triggered", int'(m_tdata[OUT_TRIG_BIT]),
                                    int'(want.triggered));
                if (m_tdata[OUT_AVG_LSB +: SAMPLE_BITS] !== want.average)
                    report_mismatch("average", int'(m_tdata[OUT_AVG_LSB +: SAMPLE_BITS]),
                                    int'(want.average));
                if (m_tdata[OUT_VALID_BIT] !== want.window_valid)
                    report_mismatch("window_valid", int'(m_tdata[OUT_VALID_BIT]),
                                    int'(want.window_valid));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_window();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_window_fill();
        test_dip_edges();
        test_sensitivity_ceiling();
        test_random_dips();

        stop_stream();
        while (pending_levels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
